// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== design/rob_pkg.sv =====
// shared types, constants and codes of the reorder buffer
`timescale 1ns / 1ps
package rob_pkg;
    localparam int ROB_DEPTH_DEF    = 16;
    localparam int COMMIT_WIDTH_DEF = 4;
    localparam int PC_REGISTER_DEF  = 30;
    localparam int TDATA_IN_W       = 72;
    localparam int TDATA_OUT_W      = 72;
    localparam int TUSER_IN_W       = 2;
    localparam int TUSER_OUT_W      = 4;

    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_WB    = 2'd1;
    localparam logic [1:0] CMD_COMMIT= 2'd2;

    localparam logic [1:0] TY_REG    = 2'd0;
    localparam logic [1:0] TY_MEM    = 2'd1;
    localparam logic [1:0] TY_BRANCH = 2'd2;
    localparam logic [1:0] TY_HALT   = 2'd3;

    localparam logic [3:0] K_ALLOC   = 4'd0;
    localparam logic [3:0] K_FULL    = 4'd1;
    localparam logic [3:0] K_WRITTEN = 4'd2;
    localparam logic [3:0] K_IGNORED = 4'd3;
    localparam logic [3:0] K_REG     = 4'd4;
    localparam logic [3:0] K_MEM     = 4'd5;
    localparam logic [3:0] K_HALT    = 4'd6;
    localparam logic [3:0] K_FLUSH   = 4'd7;
    localparam logic [3:0] K_BROK    = 4'd8;
    localparam logic [3:0] K_NONE    = 4'd9;
    localparam logic [3:0] K_PCERR   = 4'd10;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  out_tag;
        logic [15:0] out_dest;
        logic [31:0] out_value;
        logic        mispredict;
        logic [15:0] predictor_pc;
        logic        predictor_taken;
        logic        last;
    } t_result;
endpackage

// ===== design/rob_cell.sv =====
// one reorder buffer slot: holds an entry and shifts toward the head on retire
`timescale 1ns / 1ps
module rob_cell #(
    parameter int TAG_W = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic              i_flush,
    input  logic              i_load,
    input  logic              i_wb,
    input  logic              i_nb_valid,
    input  logic              i_nb_ready,
    input  logic              i_nb_mis,
    input  logic [1:0]        i_nb_type,
    input  logic [15:0]       i_nb_dest,
    input  logic [31:0]       i_nb_value,
    input  logic [15:0]       i_nb_bpc,
    input  logic [TAG_W-1:0]  i_nb_tag,
    input  logic [1:0]        i_ld_type,
    input  logic [15:0]       i_ld_dest,
    input  logic [31:0]       i_ld_value,
    input  logic [15:0]       i_ld_bpc,
    input  logic [TAG_W-1:0]  i_ld_tag,
    input  logic [15:0]       i_wb_dest,
    input  logic [31:0]       i_wb_value,
    output logic              o_valid,
    output logic              o_ready,
    output logic              o_mis,
    output logic [1:0]        o_type,
    output logic [15:0]       o_dest,
    output logic [31:0]       o_value,
    output logic [15:0]       o_bpc,
    output logic [TAG_W-1:0]  o_tag
);
    import rob_pkg::*;
    logic r_valid, r_ready, r_mis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_valid <= 1'b0;
            r_ready <= 1'b0;
            r_mis   <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_nb_valid;
            r_ready <= i_nb_ready;
            r_mis   <= i_nb_mis;
            o_type  <= i_nb_type;
            o_dest  <= i_nb_dest;
            o_value <= i_nb_value;
            o_bpc   <= i_nb_bpc;
            o_tag   <= i_nb_tag;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_ready <= (i_ld_type == TY_HALT);
            r_mis   <= 1'b0;
            o_type  <= i_ld_type;
            o_dest  <= i_ld_dest;
            o_value <= i_ld_value;
            o_bpc   <= i_ld_bpc;
            o_tag   <= i_ld_tag;
        end else if (i_wb) begin
            r_ready <= 1'b1;
            r_mis   <= (o_type == TY_BRANCH) && (i_wb_value != o_value);
            o_dest  <= i_wb_dest;
            o_value <= i_wb_value;
        end
    end
    assign o_valid = r_valid;
    assign o_ready = r_ready;
    assign o_mis   = r_mis;
endmodule

// ===== design/reorder_buffer_commit.sv =====
// Reorder buffer with in-order commit, built as a shifting chain of slots.
// Slave channel: tuser carries the command, tdata the other command fields.
// Master channel: tuser carries the result kind; one to COMMIT_WIDTH result
// beats per command, the final beat flagged by tlast. Slot 0 is the head.
// Allocate, writeback and unknown commands are answered at the accepting
// edge, so their beat is valid in the next cycle and one such command can
// be taken every cycle while the receiver keeps up.
// A commit emits its result beats after the accepting cycle, one after
// another (up to COMMIT_WIDTH, or one none beat when the head is not
// ready) whenever the output register is free; the slave side is held
// until the last beat has entered the output register.
// Each commit beat with a ready head shifts the whole chain one slot toward the head; a none beat leaves it.
// The output register holds while the receiver stalls, and the slave side
// and the commit walk wait until it is taken.
// Reset empties the buffer, frees all tags and drops any pending beat.
// A mispredicted branch at commit clears every slot at once.
`timescale 1ns / 1ps
module reorder_buffer_commit #(
    parameter int ROB_DEPTH    = rob_pkg::ROB_DEPTH_DEF,
    parameter int COMMIT_WIDTH = rob_pkg::COMMIT_WIDTH_DEF,
    parameter int PC_REGISTER  = rob_pkg::PC_REGISTER_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // instr_type, dest, predicted_taken, branch_pc, tag, value, pad
    input  logic [rob_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    // command
    input  logic [rob_pkg::TUSER_IN_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_tag, out_dest, out_value, mispredict, predictor_pc,
    // predictor_taken, pad
    output logic [rob_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    // kind
    output logic [rob_pkg::TUSER_OUT_W-1:0] m_axis_tuser,
    output logic                            m_axis_tlast
);
    import rob_pkg::*;
    localparam int TAG_W = (ROB_DEPTH > 1) ? $clog2(ROB_DEPTH) : 1;
    localparam int OCC_W = $clog2(ROB_DEPTH + 1);
    localparam int CNT_W = $clog2(COMMIT_WIDTH + 1);

    logic [1:0]  in_cmd, in_type;
    logic [15:0] in_dest, in_bpc;
    logic        in_pred;
    logic [3:0]  in_tag;
    logic [31:0] in_value;
    assign in_cmd   = s_axis_tuser;
    assign in_type  = s_axis_tdata[1:0];
    assign in_dest  = s_axis_tdata[17:2];
    assign in_pred  = s_axis_tdata[18];
    assign in_bpc   = s_axis_tdata[34:19];
    assign in_tag   = s_axis_tdata[38:35];
    assign in_value = s_axis_tdata[70:39];

    logic [ROB_DEPTH-1:0]  c_valid, c_ready, c_mis, c_load, c_wb, c_match;
    logic [1:0]            c_type  [ROB_DEPTH];
    logic [15:0]           c_dest  [ROB_DEPTH];
    logic [31:0]           c_value [ROB_DEPTH];
    logic [15:0]           c_bpc   [ROB_DEPTH];
    logic [TAG_W-1:0]      c_tag   [ROB_DEPTH];

    logic                  r_busy, r_ovalid;
    t_result               r_out, n_out;
    logic [CNT_W-1:0]      r_cnt;
    logic [OCC_W-1:0]      r_occ;
    logic [ROB_DEPTH-1:0]  r_tags;
    logic                  shift, flush, emit, done, accept, out_free;
    logic [TAG_W-1:0]      free_tag;
    logic                  free_found;

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = !r_busy && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        free_tag   = '0;
        free_found = 1'b0;
        for (int t = ROB_DEPTH - 1; t >= 0; t--) begin
            if (!r_tags[t]) begin
                free_tag   = TAG_W'(t);
                free_found = 1'b1;
            end
        end
    end

    logic [ROB_DEPTH-1:0] wb_first;
    always_comb begin
        for (int i = 0; i < ROB_DEPTH; i++) begin
            c_match[i] = c_valid[i] && !c_ready[i]
                         && (32'(in_tag) == 32'(c_tag[i]));
        end
        wb_first = c_match & (~c_match + 1'b1);
    end

    logic full;
    assign full = (r_occ == OCC_W'(ROB_DEPTH));

    always_comb begin
        for (int i = 0; i < ROB_DEPTH; i++) begin
            c_load[i] = accept && in_cmd == CMD_ALLOC && !full && r_occ == OCC_W'(i);
            c_wb[i]   = accept && in_cmd == CMD_WB && wb_first[i];
        end
    end

    logic [1:0]  ld_type;
    logic [15:0] ld_dest;
    logic [31:0] ld_value;
    assign ld_type  = in_type;
    assign ld_dest  = (in_type == TY_REG || in_type == TY_BRANCH) ? in_dest : 16'hFFFF;
    assign ld_value = (in_type == TY_BRANCH) ? {31'd0, in_pred} : 32'hFFFF_FFFF;

    // commit step at the head
    logic head_ok;
    assign head_ok = c_valid[0] && c_ready[0];
    assign emit    = r_busy && out_free;
    assign shift   = emit && head_ok;

    logic stop;
    always_comb begin
        n_out = '0;
        stop  = 1'b0;
        flush = 1'b0;
        if (!head_ok) begin
            n_out.kind = K_NONE;
        end else begin
            n_out.out_tag = 4'(c_tag[0]);
            n_out.out_dest = c_dest[0];
            case (c_type[0])
                TY_REG: begin
                    if (c_dest[0] == 16'(PC_REGISTER)) begin
                        n_out.kind = K_PCERR;
                        stop = 1'b1;
                    end else begin
                        n_out.kind = K_REG;
                        n_out.out_value = c_value[0];
                    end
                end
                TY_MEM: begin
                    n_out.kind = K_MEM;
                    n_out.out_value = c_value[0];
                end
                TY_BRANCH: begin
                    stop = 1'b1;
                    if (c_mis[0]) begin
                        n_out.kind = K_FLUSH;
                        flush = emit;
                    end else begin
                        n_out.kind = K_BROK;
                        n_out.out_value = c_value[0];
                    end
                end
                default: begin
                    n_out.kind = K_HALT;
                    n_out.out_dest = '0;
                end
            endcase
        end
        // last beat of this commit: empty head, stop, final slot, or no ready entry behind
        done = !head_ok || stop || r_cnt == CNT_W'(COMMIT_WIDTH - 1)
               || !(c_valid[1 % ROB_DEPTH] && c_ready[1 % ROB_DEPTH] && ROB_DEPTH > 1);
        n_out.last = done;
    end

    t_result in_res;
    always_comb begin
        in_res = '0;
        in_res.last = 1'b1;
        case (in_cmd)
            CMD_ALLOC: begin
                if (full) begin
                    in_res.kind = K_FULL;
                end else begin
                    in_res.kind    = K_ALLOC;
                    in_res.out_tag = 4'(free_tag);
                end
            end
            CMD_WB: begin
                if (c_match == '0) begin
                    in_res.kind = K_IGNORED;
                end else begin
                    in_res.kind      = K_WRITTEN;
                    in_res.out_tag   = in_tag;
                    in_res.out_value = in_value;
                    for (int i = 0; i < ROB_DEPTH; i++) begin
                        if (wb_first[i] && c_type[i] == TY_BRANCH) begin
                            in_res.mispredict      = (in_value != c_value[i]);
                            in_res.predictor_pc    = c_bpc[i];
                            in_res.predictor_taken = (in_value != 32'd0);
                        end
                    end
                end
            end
            default: in_res.kind = K_IGNORED;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_occ    <= '0;
            r_tags   <= '0;
        end else begin
            if (accept) begin
                if (in_cmd == CMD_COMMIT) begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    if (m_axis_tready) r_ovalid <= 1'b0;
                end else begin
                    r_ovalid <= 1'b1;
                    r_out    <= in_res;
                    if (in_cmd == CMD_ALLOC && !full && free_found) begin
                        r_tags[free_tag] <= 1'b1;
                        r_occ <= r_occ + 1'b1;
                    end
                end
            end else if (emit) begin
                r_ovalid  <= 1'b1;
                r_out     <= n_out;
                r_cnt     <= r_cnt + 1'b1;
                if (done) r_busy <= 1'b0;
                if (flush) begin
                    r_occ  <= '0;
                    r_tags <= '0;
                end else if (shift) begin
                    r_occ <= r_occ - 1'b1;
                    r_tags[c_tag[0]] <= 1'b0;
                end
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < ROB_DEPTH; g++) begin : g_cell
        localparam int NB = (g + 1 < ROB_DEPTH) ? g + 1 : g;
        logic nb_v;
        assign nb_v = (g + 1 < ROB_DEPTH) ? c_valid[NB] : 1'b0;
        rob_cell #(.TAG_W(TAG_W)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_shift(shift && !flush), .i_flush(flush),
            .i_load(c_load[g]), .i_wb(c_wb[g]),
            .i_nb_valid(nb_v), .i_nb_ready(c_ready[NB] && nb_v),
            .i_nb_mis(c_mis[NB] && nb_v),
            .i_nb_type(c_type[NB]), .i_nb_dest(c_dest[NB]), .i_nb_value(c_value[NB]),
            .i_nb_bpc(c_bpc[NB]), .i_nb_tag(c_tag[NB]),
            .i_ld_type(ld_type), .i_ld_dest(ld_dest), .i_ld_value(ld_value),
            .i_ld_bpc(in_bpc), .i_ld_tag(free_tag),
            .i_wb_dest(in_dest), .i_wb_value(in_value),
            .o_valid(c_valid[g]), .o_ready(c_ready[g]), .o_mis(c_mis[g]),
            .o_type(c_type[g]), .o_dest(c_dest[g]), .o_value(c_value[g]),
            .o_bpc(c_bpc[g]), .o_tag(c_tag[g])
        );
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {2'b00, r_out.predictor_taken, r_out.predictor_pc,
                            r_out.mispredict, r_out.out_value, r_out.out_dest,
                            r_out.out_tag};
endmodule

// ===== design/rob_checker.sv =====
// port-level checker for the reorder buffer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rob_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [rob_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    input logic [rob_pkg::TUSER_IN_W-1:0]  s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rob_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
    input logic [rob_pkg::TUSER_OUT_W-1:0] m_axis_tuser,
    input logic                            m_axis_tlast
);
    import rob_pkg::*;
    `ASSERT_IMPL(a_kind_range, i_clk, i_rst_n, m_axis_tvalid, m_axis_tuser <= K_PCERR)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    `ASSERT_NEXT(a_alloc_answer, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_ALLOC, m_axis_tvalid && m_axis_tlast && (m_axis_tuser == K_ALLOC || m_axis_tuser == K_FULL))
    `ASSERT_IMPL(a_none_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == K_NONE, m_axis_tlast)
endmodule

bind reorder_buffer_commit rob_checker u_rob_checker (.*);

// ===== verif/tb.sv =====
// testbench for the reorder buffer: random and directed command beats checked against a predictor
`timescale 1ns / 1ps
module tb;
    import rob_pkg::*;

    localparam int DEPTH = 16;
    localparam int WIDTH = 4;
    localparam int PCREG = 30;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  ityp;
        logic [15:0] dst;
        logic        pred;
        logic [15:0] bpc;
        logic [3:0]  tg;
        logic [31:0] val;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  tg;
        logic [15:0] dst;
        logic [31:0] val;
        logic        mis;
        logic [15:0] ppc;
        logic        ptk;
        logic        last;
    } t_res;

    logic i_clk, i_rst_n;
    logic s_axis_tvalid, s_axis_tready;
    logic [TDATA_IN_W-1:0] s_axis_tdata;
    logic [TUSER_IN_W-1:0] s_axis_tuser;
    logic m_axis_tvalid, m_axis_tready;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic [TUSER_OUT_W-1:0] m_axis_tuser;
    logic m_axis_tlast;

    reorder_buffer_commit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // predictor state
    logic [1:0]  rob_type [DEPTH];
    logic        rob_ready [DEPTH];
    logic [15:0] rob_dest [DEPTH];
    logic [31:0] rob_value [DEPTH];
    logic        rob_mis [DEPTH];
    logic [15:0] rob_bpc [DEPTH];
    logic [3:0]  rob_tag [DEPTH];
    int          head, occ;
    logic [DEPTH-1:0] busy_tags;

    t_cmd pending_cmds[$];
    t_res expected_beats[$];
    int   n_sent = 0, n_beats = 0, n_err = 0, n_flush = 0, n_full = 0, n_pcerr = 0;
    int   send_idle, recv_idle;
    int   hold_cycles = 0;
    bit   hold_start = 1'b0;
    int   n_queued;
    t_cmd dc;
    // accepted last cycle; drive decision uses the sampled handshake
    logic s_axis_tready_q = 1'b0;

    function automatic t_res mk(logic [3:0] k, logic [3:0] t, logic [15:0] d,
                                logic [31:0] v, logic m, logic [15:0] p, logic pt);
        t_res r;
        r.kind = k; r.tg = t; r.dst = d; r.val = v; r.mis = m; r.ppc = p;
        r.ptk = pt; r.last = 1'b0;
        return r;
    endfunction

    function automatic t_res mk_kind(logic [3:0] k);
        return mk(k, '0, '0, '0, 1'b0, '0, 1'b0);
    endfunction

    function automatic void clear_rob();
        for (int i = 0; i < DEPTH; i++) begin
            rob_ready[i] = 1'b0;
            rob_mis[i] = 1'b0;
        end
        head = 0;
        occ = 0;
        busy_tags = '0;
    endfunction

    // work out the result beats of one command
    function automatic void predict_cmd(t_cmd c);
        t_res rs[$];
        int t, s, h;
        bit hit, stop;
        if (c.cmd == CMD_ALLOC) begin
            if (occ >= DEPTH) begin
                rs.insert(rs.size(), mk_kind(K_FULL));
                n_full++;
            end else begin
                t = 0;
                while (t < DEPTH && busy_tags[t]) t++;
                s = (head + occ) % DEPTH;
                rob_type[s] = c.ityp;
                rob_ready[s] = (c.ityp == TY_HALT);
                rob_mis[s] = 1'b0;
                rob_dest[s] = (c.ityp == TY_REG || c.ityp == TY_BRANCH) ? c.dst : 16'hFFFF;
                rob_value[s] = (c.ityp == TY_BRANCH) ? {31'd0, c.pred} : 32'hFFFFFFFF;
                rob_bpc[s] = c.bpc;
                rob_tag[s] = t[3:0];
                busy_tags[t] = 1'b1;
                occ++;
                rs.insert(rs.size(), mk(K_ALLOC, t[3:0], '0, '0, 1'b0, '0, 1'b0));
            end
        end else if (c.cmd == CMD_WB) begin
            hit = 0;
            s = 0;
            for (int i = 0; i < occ && !hit; i++) begin
                s = (head + i) % DEPTH;
                if (rob_tag[s] == c.tg && !rob_ready[s]) hit = 1;
            end
            if (!hit) begin
                rs.insert(rs.size(), mk_kind(K_IGNORED));
            end else if (rob_type[s] == TY_BRANCH) begin
                rob_mis[s] = (c.val != rob_value[s]);
                rob_dest[s] = c.dst;
                rob_value[s] = c.val;
                rob_ready[s] = 1'b1;
                rs.insert(rs.size(), mk(K_WRITTEN, c.tg, '0, c.val, rob_mis[s], rob_bpc[s],
                                        c.val != 32'd0));
            end else begin
                rob_dest[s] = c.dst;
                rob_value[s] = c.val;
                rob_ready[s] = 1'b1;
                rs.insert(rs.size(), mk(K_WRITTEN, c.tg, '0, c.val, 1'b0, '0, 1'b0));
            end
        end else if (c.cmd == CMD_COMMIT) begin
            stop = 0;
            for (int k = 0; k < WIDTH && !stop; k++) begin
                h = head;
                if (occ == 0 || !rob_ready[h]) break;
                rob_ready[h] = 1'b0;
                busy_tags[rob_tag[h]] = 1'b0;
                head = (h + 1) % DEPTH;
                occ--;
                case (rob_type[h])
                    TY_REG: begin
                        if (rob_dest[h] == 16'(PCREG)) begin
                            rs.insert(rs.size(), mk(K_PCERR, rob_tag[h], rob_dest[h], '0,
                                                    1'b0, '0, 1'b0));
                            stop = 1;
                            n_pcerr++;
                        end else begin
                            rs.insert(rs.size(), mk(K_REG, rob_tag[h], rob_dest[h],
                                                    rob_value[h], 1'b0, '0, 1'b0));
                        end
                    end
                    TY_MEM: rs.insert(rs.size(), mk(K_MEM, rob_tag[h], rob_dest[h],
                                                    rob_value[h], 1'b0, '0, 1'b0));
                    TY_BRANCH: begin
                        if (rob_mis[h]) begin
                            rs.insert(rs.size(), mk(K_FLUSH, rob_tag[h], rob_dest[h], '0,
                                                    1'b0, '0, 1'b0));
                            clear_rob();
                            n_flush++;
                        end else begin
                            rs.insert(rs.size(), mk(K_BROK, rob_tag[h], rob_dest[h],
                                                    rob_value[h], 1'b0, '0, 1'b0));
                        end
                        stop = 1;
                    end
                    default: rs.insert(rs.size(), mk(K_HALT, rob_tag[h], '0, '0,
                                                     1'b0, '0, 1'b0));
                endcase
            end
            if (rs.size() == 0) rs.insert(rs.size(), mk_kind(K_NONE));
        end else begin
            rs.insert(rs.size(), mk_kind(K_IGNORED));
        end
        rs[rs.size()-1].last = 1'b1;
        foreach (rs[i]) expected_beats.insert(expected_beats.size(), rs[i]);
    endfunction

    function automatic t_cmd rand_cmd(logic [1:0] cmd, logic [1:0] ty);
        t_cmd c;
        c.cmd = cmd;
        c.ityp = ty;
        c.dst = ($urandom_range(0, 3) == 0) ? 16'(PCREG) : 16'($urandom);
        c.pred = 1'($urandom);
        c.bpc = 16'($urandom);
        c.tg = 4'($urandom);
        case ($urandom_range(0, 3))
            0: c.val = 32'($urandom_range(0, 1));
            default: c.val = $urandom;
        endcase
        return c;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end else if (!s_axis_tvalid || s_axis_tready_q) begin
            if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                s_axis_tuser <= pending_cmds[0].cmd;
                s_axis_tdata <= {1'b0, pending_cmds[0].val, pending_cmds[0].tg,
                                 pending_cmds[0].bpc, pending_cmds[0].pred,
                                 pending_cmds[0].dst, pending_cmds[0].ityp};
                s_axis_tvalid <= 1'b1;
                pending_cmds.delete(0);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        if (!i_rst_n || hold_cycles > 0)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_cmd c;
        s_axis_tready_q <= 1'b0;
        if (!i_rst_n) begin
            clear_rob();
            for (int i = 0; i < DEPTH; i++) begin
                rob_type[i] = '0; rob_dest[i] = '0; rob_value[i] = '0;
                rob_bpc[i] = '0; rob_tag[i] = '0;
            end
        end else if (s_axis_tvalid && s_axis_tready) begin
            s_axis_tready_q <= 1'b1;
            c.cmd  = s_axis_tuser;
            c.ityp = s_axis_tdata[1:0];
            c.dst  = s_axis_tdata[17:2];
            c.pred = s_axis_tdata[18];
            c.bpc  = s_axis_tdata[34:19];
            c.tg   = s_axis_tdata[38:35];
            c.val  = s_axis_tdata[70:39];
            predict_cmd(c);
            n_sent++;
        end
    end

    // receiver hold-off counter
    always @(posedge i_clk) begin
        if (hold_start) hold_cycles <= 60;
        else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    // monitor
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind = m_axis_tuser;
            got.tg   = m_axis_tdata[3:0];
            got.dst  = m_axis_tdata[19:4];
            got.val  = m_axis_tdata[51:20];
            got.mis  = m_axis_tdata[52];
            got.ppc  = m_axis_tdata[68:53];
            got.ptk  = m_axis_tdata[69];
            got.last = m_axis_tlast;
            n_beats++;
            if (expected_beats.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected beat %h", got);
            end else begin
                exp_r = expected_beats[0];
                expected_beats.delete(0);
                if (got !== exp_r) begin
                    n_err++;
                    if (n_err <= 10) begin
                        $display("mismatch: expected kind %0d tag %0d dest %h val %h",
                                 exp_r.kind, exp_r.tg, exp_r.dst, exp_r.val,
                                 " mis %b pc %h tk %b last %b",
                                 exp_r.mis, exp_r.ppc, exp_r.ptk, exp_r.last);
                        $display("          got kind %0d tag %0d dest %h val %h",
                                 got.kind, got.tg, got.dst, got.val,
                                 " mis %b pc %h tk %b last %b",
                                 got.mis, got.ppc, got.ptk, got.last);
                    end
                end
            end
        end
    end

    task automatic add_seq();
        // allocate one to six entries, send writebacks with random tags mixed with commits, then commit
        int nalloc;
        logic [1:0] ty;
        nalloc = $urandom_range(1, 6);
        for (int i = 0; i < nalloc; i++) begin
            ty = 2'($urandom);
            pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_ALLOC, ty));
        end
        for (int i = 0; i < nalloc + 1; i++) begin
            if ($urandom_range(0, 5) == 0)
                pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_COMMIT, TY_REG));
            else
                pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_WB, TY_REG));
        end
        pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_COMMIT, TY_REG));
        if ($urandom_range(0, 1))
            pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_COMMIT, TY_REG));
    endtask

    task automatic run_phase(int sidle, int ridle, int n);
        send_idle = sidle;
        recv_idle = ridle;
        while (n_queued < n) begin
            if ($urandom_range(0, 9) == 0) begin
                pending_cmds.insert(pending_cmds.size(),
                                    rand_cmd(2'($urandom), 2'($urandom)));
                n_queued++;
            end else begin
                n_queued -= pending_cmds.size();
                add_seq();
                n_queued += pending_cmds.size();
            end
            while (pending_cmds.size() != 0) @(posedge i_clk);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        n_queued = 0;
        send_idle = 0; recv_idle = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty commit, bad command, stray writeback, fill to full
        pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_COMMIT, TY_REG));
        dc = rand_cmd(CMD_UNUSED, TY_HALT); dc.dst = '1; dc.bpc = '1; dc.val = '1; dc.tg = '1;
        pending_cmds.insert(pending_cmds.size(), dc);
        pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_WB, TY_REG));
        for (int i = 0; i < DEPTH + 1; i++) begin
            dc = rand_cmd(CMD_ALLOC, 2'(i % 4));
            if (i == 0) dc.dst = 16'(PCREG);
            if (i == 1) begin dc.dst = '0; dc.bpc = '0; end
            pending_cmds.insert(pending_cmds.size(), dc);
        end
        // blocked head, then writebacks of the first entries and commits
        pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_COMMIT, TY_REG));
        dc = rand_cmd(CMD_WB, TY_REG); dc.tg = 4'd0; dc.val = 32'h80000000;
        pending_cmds.insert(pending_cmds.size(), dc);
        dc = rand_cmd(CMD_WB, TY_REG); dc.tg = 4'd1; dc.val = 32'h7FFFFFFF;
        pending_cmds.insert(pending_cmds.size(), dc);
        dc = rand_cmd(CMD_WB, TY_REG); dc.tg = 4'd2; dc.val = 32'd2;
        pending_cmds.insert(pending_cmds.size(), dc);
        pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_COMMIT, TY_REG));
        pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_COMMIT, TY_REG));
        pending_cmds.insert(pending_cmds.size(), rand_cmd(CMD_COMMIT, TY_REG));
        n_queued = pending_cmds.size();
        while (pending_cmds.size() != 0) @(posedge i_clk);

        run_phase(20, 70, 70);
        // long receiver hold-off while the sender keeps offering
        @(negedge i_clk);
        hold_start = 1'b1;
        @(negedge i_clk);
        hold_start = 1'b0;
        run_phase(70, 20, 130);
        run_phase(0, 0, 180);
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d commands, %0d result beats under mixed stalls and one long hold",
                 n_sent, n_beats);
        $display("seen %0d flushes, %0d full answers, %0d pc errors",
                 n_flush, n_full, n_pcerr);
        if (n_err == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches", n_err);
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("DONE: errors detected");
        $finish;
    end
endmodule
